FILE: rtl/dap_pkg.sv
// shared types, widths and constants for the dihedral angle pipeline
package dap_pkg;

  // field and datapath widths
  localparam int COORD_W      = 32;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int CROSS_W      = PROD_W + 1;
  localparam int LEN_BITS     = 7;
  localparam int MAG_BITS     = 30;
  localparam int NORM_W       = MAG_BITS + 1;
  localparam int SQ_W         = 2 * NORM_W;
  localparam int DOT_W        = 64;
  localparam int LEN_W        = 62;
  localparam int ROOT_W       = LEN_W / 2;
  localparam int Q_W          = 31;
  localparam int ANGLE_W      = 24;
  localparam int CORDIC_W     = 34;
  localparam int ANG_W        = 26;
  localparam int CORDIC_STEPS = 23;
  localparam int ATAN_W       = 22;

  // fixed-point constants
  localparam logic [Q_W-1:0]     UNIT_Q30 = Q_W'(1) << 30;
  localparam logic [LEN_W-1:0]   ONE_Q60  = LEN_W'(1) << 60;
  localparam logic [ANGLE_W-1:0] DEG_90   = ANGLE_W'(5898240);
  localparam logic [ANGLE_W-1:0] DEG_180  = ANGLE_W'(11796480);

  // atan(2^-i) in degrees, Q8.16
  localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
    22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2, 22'd1
  };

  // one request: four points
  typedef struct packed {
    logic signed [COORD_W-1:0] p1_x;
    logic signed [COORD_W-1:0] p1_y;
    logic signed [COORD_W-1:0] p1_z;
    logic signed [COORD_W-1:0] p2_x;
    logic signed [COORD_W-1:0] p2_y;
    logic signed [COORD_W-1:0] p2_z;
    logic signed [COORD_W-1:0] p3_x;
    logic signed [COORD_W-1:0] p3_y;
    logic signed [COORD_W-1:0] p3_z;
    logic signed [COORD_W-1:0] p4_x;
    logic signed [COORD_W-1:0] p4_y;
    logic signed [COORD_W-1:0] p4_z;
  } dap_in_t;

  // one result
  typedef struct packed {
    logic [ANGLE_W-1:0] angle_deg;
    logic               degenerate;
  } dap_out_t;

  // scaled plane normals leaving the front end
  typedef struct packed {
    logic signed [NORM_W-1:0] a_x;
    logic signed [NORM_W-1:0] a_y;
    logic signed [NORM_W-1:0] a_z;
    logic signed [NORM_W-1:0] b_x;
    logic signed [NORM_W-1:0] b_y;
    logic signed [NORM_W-1:0] b_z;
    logic                     degen;
  } dap_norm_t;

endpackage

FILE: rtl/dihedral_angle_four_points.sv
// top level: dihedral angle of four points, fully pipelined
//
// A request of four Q16.16 points is taken at each clock edge where start
// is high; busy is always low, so one request can enter every cycle.
// Each request gives exactly one result: done is high for one cycle with
// result.angle_deg (Q8.16 degrees, 0..180) and result.degenerate.
// Throughput is one request per cycle, set by the pipeline: 6 front-end
// stages, 2 for the dot and length products, 16 for the two length roots,
// 1 for the denominator product, 16 for the divider, 3 for clamp and sine
// radicand, 16 for the sine root, 1 for cordic setup, 12 for cordic and 1
// output register.
// Results come out in request order. The receiver cannot hold results off.
// Reset clears all valid bits, so nothing in flight is delivered after it.
module dihedral_angle_four_points (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  dap_pkg::dap_in_t  request,
  output logic              done,
  output dap_pkg::dap_out_t result
);
  import dap_pkg::*;

  dap_norm_t                  nrm;
  logic                       nrm_vld;
  logic signed [SQ_W-1:0]     pd [3];
  logic signed [SQ_W-1:0]     pa [3];
  logic signed [SQ_W-1:0]     pb [3];
  logic                       degen7;
  logic                       degen8;
  logic signed [DOT_W-1:0]    dot;
  logic [LEN_W-1:0]           l1;
  logic [LEN_W-1:0]           l2;
  logic [1:0]                 vld_p;
  logic                       r_vld;
  logic [ROOT_W-1:0]          r1;
  logic [ROOT_W-1:0]          r2;
  logic [DOT_W-1:0]           r_dot;
  logic                       r_degen;
  logic                       d_vld;
  logic [LEN_W-1:0]           den;
  logic [LEN_W-1:0]           num;
  logic                       d_neg;
  logic                       d_degen;
  logic                       q_vld;
  logic [Q_W-1:0]             quo;
  logic [1:0]                 q_pay;
  logic [2:0]                 vld_c;
  logic [Q_W-1:0]             qs;
  logic [Q_W-1:0]             qs2;
  logic [Q_W-1:0]             qs3;
  logic [LEN_W-1:0]           sq;
  logic [LEN_W-1:0]           rad;
  logic                       neg42;
  logic                       neg43;
  logic                       neg44;
  logic                       dg42;
  logic                       dg43;
  logic                       dg44;
  logic                       s_vld;
  logic [ROOT_W-1:0]          s_root;
  logic [Q_W+1:0]             s_pay;
  logic                       c_vld;
  logic signed [CORDIC_W-1:0] cx;
  logic signed [CORDIC_W-1:0] cy;
  logic signed [ANG_W-1:0]    cz;
  logic                       c_degen;
  logic                       z_vld;
  logic signed [ANG_W-1:0]    z_fin;
  logic                       z_degen;
  logic                       cneg;

  assign busy = 1'b0;

  // differences, normals, scaling
  dap_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .request   (request),
    .out_valid (nrm_vld),
    .nrm       (nrm)
  );

  // dot and squared-length products, then their sums
  always_ff @(posedge clk) begin
    pd[0]  <= nrm.a_x * nrm.b_x;
    pd[1]  <= nrm.a_y * nrm.b_y;
    pd[2]  <= nrm.a_z * nrm.b_z;
    pa[0]  <= nrm.a_x * nrm.a_x;
    pa[1]  <= nrm.a_y * nrm.a_y;
    pa[2]  <= nrm.a_z * nrm.a_z;
    pb[0]  <= nrm.b_x * nrm.b_x;
    pb[1]  <= nrm.b_y * nrm.b_y;
    pb[2]  <= nrm.b_z * nrm.b_z;
    degen7 <= nrm.degen;
    dot    <= DOT_W'(pd[0]) + DOT_W'(pd[1]) + DOT_W'(pd[2]);
    l1     <= LEN_W'(pa[0]) + LEN_W'(pa[1]) + LEN_W'(pa[2]);
    l2     <= LEN_W'(pb[0]) + LEN_W'(pb[1]) + LEN_W'(pb[2]);
    degen8 <= degen7;
  end

  // lengths of both normals
  dap_sqrt #(.IN_W(LEN_W), .PAY_W(DOT_W)) u_sqrt_l1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_p[1]),
    .rad_in    (l1),
    .pay_in    (dot),
    .out_valid (r_vld),
    .root_out  (r1),
    .pay_out   (r_dot)
  );

  dap_sqrt #(.IN_W(LEN_W), .PAY_W(1)) u_sqrt_l2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_p[1]),
    .rad_in    (l2),
    .pay_in    (degen8),
    .out_valid (),
    .root_out  (r2),
    .pay_out   (r_degen)
  );

  // denominator and cosine magnitude
  always_ff @(posedge clk) begin
    den     <= r1 * r2;
    num     <= r_dot[DOT_W-1] ? LEN_W'(-r_dot) : LEN_W'(r_dot);
    d_neg   <= r_dot[DOT_W-1];
    d_degen <= r_degen;
  end

  dap_div #(.PAY_W(2)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_vld),
    .num       (num),
    .den       (den),
    .pay_in    ({d_neg, d_degen}),
    .out_valid (q_vld),
    .quo       (quo),
    .pay_out   (q_pay)
  );

  // clamp the cosine, square it, form the sine radicand
  always_ff @(posedge clk) begin
    qs    <= (quo > UNIT_Q30) ? UNIT_Q30 : quo;
    neg42 <= q_pay[1];
    dg42  <= q_pay[0];
    sq    <= qs * qs;
    qs2   <= qs;
    neg43 <= neg42;
    dg43  <= dg42;
    rad   <= ONE_Q60 - sq;
    qs3   <= qs2;
    neg44 <= neg43;
    dg44  <= dg43;
  end

  dap_sqrt #(.IN_W(LEN_W), .PAY_W(Q_W + 2)) u_sqrt_s (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_c[2]),
    .rad_in    (rad),
    .pay_in    ({qs3, neg44, dg44}),
    .out_valid (s_vld),
    .root_out  (s_root),
    .pay_out   (s_pay)
  );

  // cordic start vector, pre-turned for a negative cosine
  assign cneg = s_pay[1] && (s_pay[Q_W+1:2] != '0);

  always_ff @(posedge clk) begin
    cx      <= cneg ? CORDIC_W'(s_root) : CORDIC_W'(s_pay[Q_W+1:2]);
    cy      <= cneg ? CORDIC_W'(s_pay[Q_W+1:2]) : CORDIC_W'(s_root);
    cz      <= cneg ? ANG_W'(DEG_90) : '0;
    c_degen <= s_pay[0];
  end

  dap_cordic #(.PAY_W(1)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_vld),
    .x_in      (cx),
    .y_in      (cy),
    .z_in      (cz),
    .pay_in    (c_degen),
    .out_valid (z_vld),
    .z_out     (z_fin),
    .pay_out   (z_degen)
  );

  // final clamp and output register
  always_ff @(posedge clk) begin
    result.degenerate <= z_degen;
    priority if (z_degen) begin
      result.angle_deg <= '0;
    end else if (z_fin < 0) begin
      result.angle_deg <= '0;
    end else if (z_fin > ANG_W'(DEG_180)) begin
      result.angle_deg <= DEG_180;
    end else begin
      result.angle_deg <= z_fin[ANGLE_W-1:0];
    end
  end

  // valid bits of the stages kept here
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= '0;
      d_vld <= 1'b0;
      vld_c <= '0;
      c_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      vld_p <= {vld_p[0], nrm_vld};
      d_vld <= r_vld;
      vld_c <= {vld_c[1:0], q_vld};
      c_vld <= s_vld;
      done  <= z_vld;
    end
  end

endmodule

FILE: rtl/dap_front.sv
// front end: differences, cross products and normal scaling, six stages
module dap_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  dap_pkg::dap_in_t  request,
  output logic              out_valid,
  output dap_pkg::dap_norm_t nrm
);
  import dap_pkg::*;

  logic signed [DIFF_W-1:0]  v1 [3];
  logic signed [DIFF_W-1:0]  v2 [3];
  logic signed [DIFF_W-1:0]  v3 [3];
  logic signed [PROD_W-1:0]  pr [12];
  logic signed [CROSS_W-1:0] n [6];
  logic [CROSS_W-1:0]        mag4 [6];
  logic                      sg4 [6];
  logic [CROSS_W-1:0]        mag5 [6];
  logic                      sg5 [6];
  logic [LEN_BITS-1:0]       len1;
  logic [LEN_BITS-1:0]       len2;
  logic [CROSS_W-1:0]        mag_c [6];
  logic signed [NORM_W-1:0]  sc_c [6];
  logic [5:0]                vld;

  // bit length of a magnitude
  function automatic logic [LEN_BITS-1:0] bitlen(input logic [CROSS_W-1:0] v);
    logic [LEN_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < CROSS_W; i++) begin
      if (v[i]) r = LEN_BITS'(i + 1);
    end
    return r;
  endfunction

  // magnitudes of the cross products
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      mag_c[k] = n[k][CROSS_W-1] ? CROSS_W'(-n[k]) : CROSS_W'(n[k]);
    end
  end

  // shift each normal so its largest magnitude lands in [2^29, 2^30)
  always_comb begin
    logic [CROSS_W+MAG_BITS-1:0] wide;
    logic [LEN_BITS-1:0]         sh;
    for (int k = 0; k < 6; k++) begin
      sh   = (k < 3) ? len1 : len2;
      wide = {mag5[k], {MAG_BITS{1'b0}}} >> sh;
      sc_c[k] = sg5[k] ? -NORM_W'({1'b0, wide[MAG_BITS-1:0]})
                       : NORM_W'({1'b0, wide[MAG_BITS-1:0]});
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    v1[0] <= DIFF_W'(request.p1_x) - DIFF_W'(request.p2_x);
    v1[1] <= DIFF_W'(request.p1_y) - DIFF_W'(request.p2_y);
    v1[2] <= DIFF_W'(request.p1_z) - DIFF_W'(request.p2_z);
    v2[0] <= DIFF_W'(request.p2_x) - DIFF_W'(request.p3_x);
    v2[1] <= DIFF_W'(request.p2_y) - DIFF_W'(request.p3_y);
    v2[2] <= DIFF_W'(request.p2_z) - DIFF_W'(request.p3_z);
    v3[0] <= DIFF_W'(request.p3_x) - DIFF_W'(request.p4_x);
    v3[1] <= DIFF_W'(request.p3_y) - DIFF_W'(request.p4_y);
    v3[2] <= DIFF_W'(request.p3_z) - DIFF_W'(request.p4_z);
    // cross product terms
    pr[0]  <= v1[1] * v2[2];
    pr[1]  <= v1[2] * v2[1];
    pr[2]  <= v1[2] * v2[0];
    pr[3]  <= v1[0] * v2[2];
    pr[4]  <= v1[0] * v2[1];
    pr[5]  <= v1[1] * v2[0];
    pr[6]  <= v2[1] * v3[2];
    pr[7]  <= v2[2] * v3[1];
    pr[8]  <= v2[2] * v3[0];
    pr[9]  <= v2[0] * v3[2];
    pr[10] <= v2[0] * v3[1];
    pr[11] <= v2[1] * v3[0];
    for (int k = 0; k < 6; k++) begin
      n[k]    <= CROSS_W'(pr[2*k]) - CROSS_W'(pr[2*k+1]);
      mag4[k] <= mag_c[k];
      sg4[k]  <= n[k][CROSS_W-1];
      mag5[k] <= mag4[k];
      sg5[k]  <= sg4[k];
    end
    len1 <= bitlen(mag4[0] | mag4[1] | mag4[2]);
    len2 <= bitlen(mag4[3] | mag4[4] | mag4[5]);
    nrm.a_x   <= sc_c[0];
    nrm.a_y   <= sc_c[1];
    nrm.a_z   <= sc_c[2];
    nrm.b_x   <= sc_c[3];
    nrm.b_y   <= sc_c[4];
    nrm.b_z   <= sc_c[5];
    nrm.degen <= (len1 == '0) || (len2 == '0);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], in_valid};
    end
  end

  assign out_valid = vld[5];

endmodule

FILE: rtl/dap_sqrt.sv
// pipelined integer square root, two result bits per stage
module dap_sqrt #(
  parameter int IN_W  = dap_pkg::LEN_W,
  parameter int PAY_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   rad_in,
  input  logic [PAY_W-1:0]  pay_in,
  output logic              out_valid,
  output logic [IN_W/2-1:0] root_out,
  output logic [PAY_W-1:0]  pay_out
);
  import dap_pkg::*;

  localparam int R      = IN_W / 2;
  localparam int STAGES = (R + 1) / 2;
  localparam int REM_W  = R + 3;

  logic [REM_W-1:0] rem_s  [STAGES+1];
  logic [R-1:0]     root_s [STAGES+1];
  logic [IN_W-1:0]  rad_s  [STAGES+1];
  logic [PAY_W-1:0] pay_s  [STAGES+1];
  logic             vld_s  [STAGES+1];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = rad_in;
  assign pay_s[0]  = pay_in;
  assign vld_s[0]  = in_valid;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [REM_W-1:0] rem_c;
    logic [R-1:0]     root_c;
    logic [IN_W-1:0]  rad_c;

    // two restoring digit steps
    always_comb begin
      rem_c  = rem_s[g];
      root_c = root_s[g];
      rad_c  = rad_s[g];
      for (int j = 0; j < 2; j++) begin
        if (2 * g + j < R) begin
          rem_c = {rem_c[REM_W-3:0], rad_c[IN_W-1 -: 2]};
          rad_c = rad_c << 2;
          if (rem_c >= REM_W'({root_c, 2'b01})) begin
            rem_c  = rem_c - REM_W'({root_c, 2'b01});
            root_c = {root_c[R-2:0], 1'b1};
          end else begin
            root_c = {root_c[R-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_s[g+1]  <= rem_c;
      root_s[g+1] <= root_c;
      rad_s[g+1]  <= rad_c;
      pay_s[g+1]  <= pay_s[g];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[g+1] <= 1'b0;
      end else begin
        vld_s[g+1] <= vld_s[g];
      end
    end
  end

  assign out_valid = vld_s[STAGES];
  assign root_out  = root_s[STAGES];
  assign pay_out   = pay_s[STAGES];

endmodule

FILE: rtl/dap_div.sv
// pipelined restoring divider for the Q1.30 cosine, two quotient bits per stage
module dap_div #(
  parameter int PAY_W = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [dap_pkg::LEN_W-1:0] num,
  input  logic [dap_pkg::LEN_W-1:0] den,
  input  logic [PAY_W-1:0]          pay_in,
  output logic                      out_valid,
  output logic [dap_pkg::Q_W-1:0]   quo,
  output logic [PAY_W-1:0]          pay_out
);
  import dap_pkg::*;

  localparam int STAGES = (Q_W + 1) / 2;
  localparam int REM_W  = LEN_W + 1;

  logic [REM_W-1:0] rem_s [STAGES+1];
  logic [LEN_W-1:0] den_s [STAGES+1];
  logic [Q_W-1:0]   q_s   [STAGES+1];
  logic [PAY_W-1:0] pay_s [STAGES+1];
  logic             vld_s [STAGES+1];

  assign rem_s[0] = REM_W'(num);
  assign den_s[0] = den;
  assign q_s[0]   = '0;
  assign pay_s[0] = pay_in;
  assign vld_s[0] = in_valid;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [REM_W-1:0] rem_c;
    logic [Q_W-1:0]   q_c;

    // integer bit first, then one fraction bit per step
    always_comb begin
      rem_c = rem_s[g];
      q_c   = q_s[g];
      for (int j = 0; j < 2; j++) begin
        if (2 * g + j < Q_W) begin
          if (2 * g + j != 0) rem_c = rem_c << 1;
          if (rem_c >= REM_W'(den_s[g])) begin
            rem_c = rem_c - REM_W'(den_s[g]);
            q_c   = {q_c[Q_W-2:0], 1'b1};
          end else begin
            q_c   = {q_c[Q_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_s[g+1] <= rem_c;
      den_s[g+1] <= den_s[g];
      q_s[g+1]   <= q_c;
      pay_s[g+1] <= pay_s[g];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[g+1] <= 1'b0;
      end else begin
        vld_s[g+1] <= vld_s[g];
      end
    end
  end

  assign out_valid = vld_s[STAGES];
  assign quo       = q_s[STAGES];
  assign pay_out   = pay_s[STAGES];

endmodule

FILE: rtl/dap_cordic.sv
// pipelined cordic vectoring, two micro-rotations per stage
module dap_cordic #(
  parameter int PAY_W = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [dap_pkg::CORDIC_W-1:0] x_in,
  input  logic signed [dap_pkg::CORDIC_W-1:0] y_in,
  input  logic signed [dap_pkg::ANG_W-1:0]    z_in,
  input  logic [PAY_W-1:0]                    pay_in,
  output logic                                out_valid,
  output logic signed [dap_pkg::ANG_W-1:0]    z_out,
  output logic [PAY_W-1:0]                    pay_out
);
  import dap_pkg::*;

  localparam int STAGES = (CORDIC_STEPS + 1) / 2;

  logic signed [CORDIC_W-1:0] x_s [STAGES+1];
  logic signed [CORDIC_W-1:0] y_s [STAGES+1];
  logic signed [ANG_W-1:0]    z_s [STAGES+1];
  logic [PAY_W-1:0]           pay_s [STAGES+1];
  logic                       vld_s [STAGES+1];

  assign x_s[0]   = x_in;
  assign y_s[0]   = y_in;
  assign z_s[0]   = z_in;
  assign pay_s[0] = pay_in;
  assign vld_s[0] = in_valid;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic signed [CORDIC_W-1:0] x_c;
    logic signed [CORDIC_W-1:0] y_c;
    logic signed [ANG_W-1:0]    z_c;

    // rotate toward the x axis, accumulate the angle
    always_comb begin
      logic signed [CORDIC_W-1:0] dx;
      logic signed [CORDIC_W-1:0] dy;
      x_c = x_s[g];
      y_c = y_s[g];
      z_c = z_s[g];
      for (int j = 0; j < 2; j++) begin
        if (2 * g + j < CORDIC_STEPS) begin
          dx = y_c >>> (2 * g + j);
          dy = x_c >>> (2 * g + j);
          if (y_c > 0) begin
            x_c = x_c + dx;
            y_c = y_c - dy;
            z_c = z_c + ANG_W'(ATAN_TAB[2*g+j]);
          end else if (y_c < 0) begin
            x_c = x_c - dx;
            y_c = y_c + dy;
            z_c = z_c - ANG_W'(ATAN_TAB[2*g+j]);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      x_s[g+1]   <= x_c;
      y_s[g+1]   <= y_c;
      z_s[g+1]   <= z_c;
      pay_s[g+1] <= pay_s[g];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[g+1] <= 1'b0;
      end else begin
        vld_s[g+1] <= vld_s[g];
      end
    end
  end

  assign out_valid = vld_s[STAGES];
  assign z_out     = z_s[STAGES];
  assign pay_out   = pay_s[STAGES];

endmodule
